@@ src/size_class_chain_planner_top_defines.svh @@
// assertion macros for the chain planner
`ifndef SIZE_CLASS_CHAIN_PLANNER_TOP_DEFINES_SVH
`define SIZE_CLASS_CHAIN_PLANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define SCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("scp assertion failed");
// implication checked on every rising clock edge outside reset
`define SCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scp implication failed");
`else
`define SCP_ASSERT(lbl, prop)
`define SCP_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

@@ src/scp_pkg.sv @@
// shared types and constants of the chain planner
package scp_pkg;

  localparam int unsigned SizeW = 13;

  // one classified request between front and back
  typedef struct packed {
    logic [SizeW-1:0] size;
    logic             pow2;
    logic             start;
  } item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_DONE
  } state_e;

endpackage

@@ src/scp_front.sv @@
// front end: size clamp, power-of-two check and a two-entry queue
module scp_front #(
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  output logic                        full_o,
  input  logic [scp_pkg::SizeW-1:0]   class_size_i,
  input  logic                        pool_start_i,
  output logic                        valid_o,
  output scp_pkg::item_t              item_o,
  input  logic                        take_i
);

  localparam logic [16:0] PageV = 17'(PAGE_BYTES);

  scp_pkg::item_t            entry_q [2];
  logic                      wr_q, wr_d, rd_q, rd_d;
  logic [1:0]                cnt_q, cnt_d;
  logic [scp_pkg::SizeW-1:0] s_nz, s_cl;
  scp_pkg::item_t            new_item;
  logic                      do_push, do_pop;

  // clamp and classify the incoming size
  always_comb begin
    s_nz = (class_size_i == '0) ? scp_pkg::SizeW'(1) : class_size_i;
    s_cl = ({4'd0, s_nz} > PageV) ? scp_pkg::SizeW'(PAGE_BYTES) : s_nz;
    new_item.size  = s_cl;
    new_item.pow2  = ((s_cl & (s_cl - scp_pkg::SizeW'(1))) == '0);
    new_item.start = pool_start_i;
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;
  assign item_o  = entry_q[rd_q];

  // queue pointers
  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= new_item;
    end
  end

endmodule

@@ src/scp_back.sv @@
// back end: chain length search, merge tracking and result register
module scp_back #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_CHAIN  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      policy_mode_i,
  input  logic                      valid_i,
  input  scp_pkg::item_t            item_i,
  output logic                      take_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output logic [3:0]                chain_pages_o,
  output logic [15:0]               objects_per_chain_o,
  output logic [11:0]               end_slack_o,
  output logic [2:0]                straddle_count_o,
  output logic                      merged_o,
  output logic [scp_pkg::SizeW-1:0] physical_size_o
);

  localparam int unsigned SW = scp_pkg::SizeW;
  localparam int unsigned PW = $clog2(PAGE_BYTES) + 1;
  localparam int unsigned BW = (PW > 1) ? $clog2(PW) : 1;
  localparam int unsigned CW = $clog2(MAX_CHAIN + 1);
  localparam logic [PW-1:0] PageV = PW'(PAGE_BYTES);
  localparam logic [23:0]   PageW = 24'(PAGE_BYTES);

  scp_pkg::state_e state_q, state_d;

  logic [SW-1:0] size_q, size_d;
  logic          pow2_q, pow2_d, start_q, start_d, mode_q, mode_d;
  logic [BW-1:0] bidx_q, bidx_d;
  logic [SW-1:0] r0_q, r0_d, racc_q, racc_d, bw_q, bw_d;
  logic [15:0]   q0_q, q0_d, qacc_q, qacc_d, bobj_q, bobj_d;
  logic [CW-1:0] i_q, i_d, cnt_q, cnt_d, best_q, best_d, bstr_q, bstr_d;

  logic          prev_valid_q, prev_valid_d;
  logic [3:0]    prev_pages_q, prev_pages_d;
  logic [15:0]   prev_obj_q, prev_obj_d;
  logic [SW-1:0] prev_size_q, prev_size_d;
  logic [11:0]   prev_tail_q, prev_tail_d;
  logic [2:0]    prev_str_q, prev_str_d;

  logic          ov_q, ov_d;
  logic [3:0]    o_pages_q, o_pages_d;
  logic [15:0]   o_obj_q, o_obj_d;
  logic [11:0]   o_tail_q, o_tail_d;
  logic [2:0]    o_str_q, o_str_d;
  logic          o_mrg_q, o_mrg_d;
  logic [SW-1:0] o_size_q, o_size_d;

  logic [SW:0]   dv_t, st_sum;
  logic          dv_ge, wrap;
  logic [SW-1:0] w;
  logic [15:0]   qn;
  logic          upd, fin, first, last, out_free;
  logic [SW-1:0] bw_n;
  logic [CW-1:0] bp_n;
  logic [3:0]    new_pages;
  logic          mrg;

  assign out_free = !ov_q || pop_i;
  assign take_o   = (state_q == scp_pkg::ST_IDLE) && valid_i;

  // divider step for the page remainder
  always_comb begin
    dv_t  = {r0_q, PageV[bidx_q]};
    dv_ge = (dv_t >= {1'b0, size_q});
  end

  // one chain length per cycle, remainder carried from the previous length
  always_comb begin
    st_sum = {1'b0, racc_q} + {1'b0, r0_q};
    wrap   = (st_sum >= {1'b0, size_q});
    w      = wrap ? SW'(st_sum - {1'b0, size_q}) : SW'(st_sum);
    qn     = qacc_q + q0_q + {15'd0, wrap};
    first  = (i_q == CW'(1));
    last   = (i_q == CW'(MAX_CHAIN));
    upd    = 1'b0;
    fin    = last || pow2_q;
    if (!mode_q) begin
      upd = first || (w < bw_q);
    end else if (w == '0) begin
      upd = 1'b1;
      fin = 1'b1;
    end else if (first || (24'(bw_q) * 24'd10 > 24'(best_q) * PageW)) begin
      upd = first || (w < bw_q);
    end else begin
      upd = (24'(w) * 24'd4 < 24'(bw_q) * 24'd3);
    end
    bw_n = upd ? w : bw_q;
    bp_n = upd ? i_q : best_q;
    if (mode_q && (24'(bw_n) * 24'd64 <= 24'(bp_n) * PageW)) begin
      fin = 1'b1;
    end
  end

  // merge decision against the last unmerged class
  always_comb begin
    new_pages = 4'(best_q);
    mrg = prev_valid_q && !start_q && (new_pages == prev_pages_q) && (bobj_q == prev_obj_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scp_pkg::ST_IDLE: if (valid_i) state_d = scp_pkg::ST_DIV;
      scp_pkg::ST_DIV:  if (bidx_q == '0) state_d = scp_pkg::ST_STEP;
      scp_pkg::ST_STEP: if (fin) state_d = scp_pkg::ST_DONE;
      scp_pkg::ST_DONE: if (out_free) state_d = scp_pkg::ST_IDLE;
      default:          state_d = scp_pkg::ST_IDLE;
    endcase
  end

  // datapath updates per state
  always_comb begin
    size_d = size_q;  pow2_d = pow2_q;  start_d = start_q;  mode_d = mode_q;
    bidx_d = bidx_q;  r0_d = r0_q;  q0_d = q0_q;
    racc_d = racc_q;  qacc_d = qacc_q;  i_d = i_q;  cnt_d = cnt_q;
    best_d = best_q;  bw_d = bw_q;  bobj_d = bobj_q;  bstr_d = bstr_q;
    prev_valid_d = prev_valid_q;  prev_pages_d = prev_pages_q;
    prev_obj_d = prev_obj_q;  prev_size_d = prev_size_q;
    prev_tail_d = prev_tail_q;  prev_str_d = prev_str_q;
    ov_d = ov_q && !pop_i;
    o_pages_d = o_pages_q;  o_obj_d = o_obj_q;  o_tail_d = o_tail_q;
    o_str_d = o_str_q;  o_mrg_d = o_mrg_q;  o_size_d = o_size_q;
    unique case (state_q)
      scp_pkg::ST_IDLE: begin
        size_d  = item_i.size;
        pow2_d  = item_i.pow2;
        start_d = item_i.start;
        mode_d  = policy_mode_i;
        bidx_d  = BW'(PW - 1);
        r0_d    = '0;
        q0_d    = '0;
      end
      scp_pkg::ST_DIV: begin
        r0_d   = dv_ge ? SW'(dv_t - {1'b0, size_q}) : SW'(dv_t);
        q0_d   = {q0_q[14:0], dv_ge};
        bidx_d = bidx_q - BW'(1);
        racc_d = '0;
        qacc_d = '0;
        i_d    = CW'(1);
        cnt_d  = '0;
      end
      scp_pkg::ST_STEP: begin
        racc_d = w;
        qacc_d = qn;
        i_d    = i_q + CW'(1);
        cnt_d  = cnt_q + CW'(w != '0);
        if (upd) begin
          best_d = i_q;
          bw_d   = w;
          bobj_d = qn;
          bstr_d = cnt_q;
        end
      end
      scp_pkg::ST_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          o_mrg_d = mrg;
          if (mrg) begin
            o_pages_d = prev_pages_q;
            o_obj_d   = prev_obj_q;
            o_tail_d  = prev_tail_q;
            o_str_d   = prev_str_q;
            o_size_d  = prev_size_q;
          end else begin
            prev_valid_d = 1'b1;
            prev_pages_d = new_pages;
            prev_obj_d   = bobj_q;
            prev_size_d  = size_q;
            prev_tail_d  = (new_pages == 4'd0) ? 12'd0 : 12'(bw_q);
            prev_str_d   = (new_pages == 4'd0) ? 3'd0 : 3'(bstr_q);
            o_pages_d    = new_pages;
            o_obj_d      = bobj_q;
            o_tail_d     = (new_pages == 4'd0) ? 12'd0 : 12'(bw_q);
            o_str_d      = (new_pages == 4'd0) ? 3'd0 : 3'(bstr_q);
            o_size_d     = size_q;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= scp_pkg::ST_IDLE;
      ov_q         <= 1'b0;
      prev_valid_q <= 1'b0;
      prev_pages_q <= '0;
      prev_obj_q   <= '0;
      prev_size_q  <= '0;
      prev_tail_q  <= '0;
      prev_str_q   <= '0;
    end else begin
      state_q      <= state_d;
      ov_q         <= ov_d;
      prev_valid_q <= prev_valid_d;
      prev_pages_q <= prev_pages_d;
      prev_obj_q   <= prev_obj_d;
      prev_size_q  <= prev_size_d;
      prev_tail_q  <= prev_tail_d;
      prev_str_q   <= prev_str_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    size_q <= size_d;  pow2_q <= pow2_d;  start_q <= start_d;  mode_q <= mode_d;
    bidx_q <= bidx_d;  r0_q <= r0_d;  q0_q <= q0_d;
    racc_q <= racc_d;  qacc_q <= qacc_d;  i_q <= i_d;  cnt_q <= cnt_d;
    best_q <= best_d;  bw_q <= bw_d;  bobj_q <= bobj_d;  bstr_q <= bstr_d;
    o_pages_q <= o_pages_d;  o_obj_q <= o_obj_d;  o_tail_q <= o_tail_d;
    o_str_q <= o_str_d;  o_mrg_q <= o_mrg_d;  o_size_q <= o_size_d;
  end

  assign empty_o             = !ov_q;
  assign chain_pages_o       = o_pages_q;
  assign objects_per_chain_o = o_obj_q;
  assign end_slack_o         = o_tail_q;
  assign straddle_count_o    = o_str_q;
  assign merged_o            = o_mrg_q;
  assign physical_size_o     = o_size_q;

endmodule

@@ src/size_class_chain_planner_top.sv @@
// top level of the slab size-class chain planner
//
// Input queue: drive class_size_i and pool_start_i with push; a request is
// taken when push is high and full is low. Two requests can wait in the
// front queue while the back end works on a third.
// Result queue: while empty is low the oldest result sits on the result
// ports; pop takes it. A finished result waits in the output register
// until popped, and the back end holds its next result until then.
// Configuration: cfg_we_i writes cfg_wdata_i into the policy mode (reset
// 1, thresholded). A request samples the mode when the back end starts it.
// Sequence: one request at a time in the back end. It is loaded in the idle
// state, the page remainder comes from a bit-serial divider over the bits of
// PAGE_BYTES, then chain lengths 1 to MAX_CHAIN are tried in turn until the
// search stops, and then the result goes to the output register.
// Reset clears both queues and the merge history and sets thresholded mode.
`include "size_class_chain_planner_top_defines.svh"

module size_class_chain_planner_top #(
  parameter int unsigned PAGE_BYTES = 4096,
  parameter int unsigned MAX_CHAIN  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [12:0]               class_size_i,
  input  logic                      pool_start_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [3:0]                chain_pages_o,
  output logic [15:0]               objects_per_chain_o,
  output logic [11:0]               end_slack_o,
  output logic [2:0]                straddle_count_o,
  output logic                      merged_o,
  output logic [12:0]               physical_size_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_wdata_i
);

  logic           mode_q, mode_d;
  logic           fv, take;
  scp_pkg::item_t fitem;

  // policy mode register
  assign mode_d = cfg_we_i ? cfg_wdata_i : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else begin
      mode_q <= mode_d;
    end
  end

  // request intake
  scp_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .class_size_i (class_size_i),
    .pool_start_i (pool_start_i),
    .valid_o      (fv),
    .item_o       (fitem),
    .take_i       (take)
  );

  // chain search and results
  scp_back #(.PAGE_BYTES(PAGE_BYTES), .MAX_CHAIN(MAX_CHAIN)) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .policy_mode_i       (mode_q),
    .valid_i             (fv),
    .item_i              (fitem),
    .take_o              (take),
    .empty_o             (empty),
    .pop_i               (pop),
    .chain_pages_o       (chain_pages_o),
    .objects_per_chain_o (objects_per_chain_o),
    .end_slack_o         (end_slack_o),
    .straddle_count_o    (straddle_count_o),
    .merged_o            (merged_o),
    .physical_size_o     (physical_size_o)
  );

  // result sanity checks
  `SCP_ASSERT_IMP(a_size_nonzero, !empty, physical_size_o != 13'd0)
  `SCP_ASSERT_IMP(a_slack_below_size, !empty, 13'(end_slack_o) < physical_size_o)
  `SCP_ASSERT_IMP(a_straddle_below_pages, !empty, 4'(straddle_count_o) < chain_pages_o)

endmodule

@@ verif/tb_size_class_chain_planner_top.sv @@
// testbench for the slab size-class chain planner with a predicting checker
module tb_size_class_chain_planner_top;

  localparam int unsigned PageBytes  = 4096;
  localparam int unsigned MaxChain   = 8;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned HoldCycles = 300;
  localparam bit          PolicyMinWaste  = 1'b0;
  localparam bit          PolicyThreshold = 1'b1;

  typedef struct {
    logic [3:0]  pages;
    logic [15:0] objects;
    logic [11:0] waste;
    logic [2:0]  straddles;
    logic        merged;
    logic [12:0] phys_size;
  } plan_t;

  logic        clk_i, rst_ni;
  logic        push, full, empty, pop;
  logic [12:0] class_size_i;
  logic        pool_start_i;
  logic [3:0]  chain_pages_o;
  logic [15:0] objects_per_chain_o;
  logic [11:0] end_slack_o;
  logic [2:0]  straddle_count_o;
  logic        merged_o;
  logic [12:0] physical_size_o;
  logic        cfg_we_i, cfg_wdata_i;

  // predictor state
  bit          policy_q;
  bit          hist_valid;
  logic [3:0]  hist_pages;
  logic [15:0] hist_objects;
  logic [12:0] hist_size;
  plan_t       pending_plans[$];

  int  errors;
  int  quiet_cycles;
  bit  idle_allowed;
  bit  hold_req;

  size_class_chain_planner_top uut (
    .clk_i, .rst_ni, .push, .full, .class_size_i, .pool_start_i,
    .empty, .pop, .chain_pages_o, .objects_per_chain_o, .end_slack_o,
    .straddle_count_o, .merged_o, .physical_size_o, .cfg_we_i, .cfg_wdata_i
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // chain length for a clamped, non power-of-two size
  function automatic int unsigned choose_pages(longint unsigned s, bit thresholded);
    int unsigned     best;
    longint unsigned best_w, w;
    bit              have;
    best = 1;
    best_w = 0;
    have = 0;
    for (int unsigned i = 1; i <= MaxChain; i++) begin
      w = (longint'(i) * PageBytes) % s;
      if (!thresholded) begin
        if (!have || w < best_w) begin
          best_w = w;
          best = i;
          have = 1;
        end
      end else begin
        if (w == 0) return i;
        if (!have || best_w * 10 > longint'(best) * PageBytes) begin
          if (!have || w < best_w) begin
            best_w = w;
            best = i;
            have = 1;
          end
        end else if (w * 4 < best_w * 3) begin
          best_w = w;
          best = i;
        end
        if (best_w * 64 <= longint'(best) * PageBytes) break;
      end
    end
    return best;
  endfunction

  // expected plan for one accepted class, updating merge history
  function automatic plan_t plan_class(logic [12:0] raw, logic start);
    plan_t           p;
    longint unsigned s, psize;
    int unsigned     pages, nstr;
    logic [15:0]     objs;
    s = (raw == 0) ? 1 : raw;
    if (s > PageBytes) s = PageBytes;
    if ((s & (s - 1)) == 0) pages = 1;
    else pages = choose_pages(s, policy_q);
    objs = 16'((longint'(pages) * PageBytes) / s);
    if (start) hist_valid = 0;
    p.merged = hist_valid && pages[3:0] == hist_pages && objs == hist_objects;
    if (!p.merged) begin
      hist_valid = 1;
      hist_pages = pages[3:0];
      hist_objects = objs;
      hist_size = 13'(s);
    end
    psize = (hist_size != 0) ? hist_size : 1;
    nstr = 0;
    for (int unsigned k = 1; k < hist_pages; k++)
      if ((longint'(k) * PageBytes) % psize != 0) nstr++;
    p.pages = hist_pages;
    p.objects = hist_objects;
    p.waste = 12'((longint'(hist_pages) * PageBytes) % psize);
    p.straddles = 3'(nstr);
    p.phys_size = 13'(psize);
    return p;
  endfunction

  // handshake monitor: predict on input, compare on output, watchdog
  always @(posedge clk_i) begin
    plan_t e;
    bit    moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (push && !full) begin
        pending_plans.push_back(plan_class(class_size_i, pool_start_i));
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (pending_plans.size() == 0) begin
          $error("unexpected result: pages %0d size %0d", chain_pages_o, physical_size_o);
          errors++;
        end else begin
          e = pending_plans.pop_front();
          if (chain_pages_o !== e.pages) begin
            $error("chain_pages exp %0d got %0d", e.pages, chain_pages_o); errors++;
          end
          if (objects_per_chain_o !== e.objects) begin
            $error("objects_per_chain exp %0d got %0d", e.objects, objects_per_chain_o);
            errors++;
          end
          if (end_slack_o !== e.waste) begin
            $error("end_slack exp %0d got %0d", e.waste, end_slack_o); errors++;
          end
          if (straddle_count_o !== e.straddles) begin
            $error("straddle_count exp %0d got %0d", e.straddles, straddle_count_o);
            errors++;
          end
          if (merged_o !== e.merged) begin
            $error("merged exp %0d got %0d", e.merged, merged_o); errors++;
          end
          if (physical_size_o !== e.phys_size) begin
            $error("physical_size exp %0d got %0d", e.phys_size, physical_size_o); errors++;
          end
        end
      end
      if (moved) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // result side: random stall bursts, or one long hold when asked
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 0;
      end
      if (idle_allowed && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      pop <= 1'b1;
    end
  end

  // send one request and wait until it is taken; push stays high afterwards
  task automatic send_class(logic [12:0] size, logic start);
    if (idle_allowed && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    push <= 1'b1;
    class_size_i <= size;
    pool_start_i <= start;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // stop offering requests after the last send of a test
  task automatic release_push();
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  // drain all results, then let the back end settle before a register write
  task automatic set_policy(bit mode);
    while (pending_plans.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    policy_q = mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // extremes, powers of two, zero size, clamping and merges
  task automatic test_directed();
    logic [12:0] sizes[] = '{13'd8191, 13'd4097, 13'd4096, 13'd4095, 13'd3264,
                             13'd2048, 13'd1365, 13'd1360, 13'd1000, 13'd640,
                             13'd512, 13'd96, 13'd7, 13'd3, 13'd2, 13'd1, 13'd0};
    foreach (sizes[i]) send_class(sizes[i], i == 0);
    // same plan twice in a row merges, pool start clears it
    send_class(13'd3000, 1'b0);
    send_class(13'd2999, 1'b0);
    send_class(13'd2998, 1'b1);
    send_class(13'd2997, 1'b0);
    release_push();
  endtask

  // descending pools with random content, plus noise
  task automatic test_random_pools(int unsigned n);
    int unsigned sent;
    logic [12:0] s;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 4) == 0) begin
        send_class(13'($urandom), 1'($urandom));
        sent++;
      end else begin
        s = 13'($urandom_range(1, 4200));
        for (int j = $urandom_range(4, 20); j > 0 && sent < n; j--) begin
          send_class(s, j == 0 ? 1'b0 : 1'b0);
          sent++;
          if (s > 8) s = s - 13'($urandom_range(0, s > 64 ? 64 : 1));
        end
        send_class(13'($urandom_range(1, 8191)), 1'b1);
        sent++;
      end
    end
    release_push();
  endtask

  // long receiver hold while requests keep coming
  task automatic test_backpressure();
    hold_req = 1;
    for (int i = 0; i < 12; i++) send_class(13'($urandom_range(1, 4096)), i == 0);
    release_push();
  endtask

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    class_size_i = '0;
    pool_start_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    idle_allowed = 1;
    hold_req = 0;
    policy_q = PolicyThreshold;
    hist_valid = 0;
    hist_pages = '0;
    hist_objects = '0;
    hist_size = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    set_policy(PolicyMinWaste);
    test_directed();
    test_random_pools(200);
    set_policy(PolicyThreshold);
    test_random_pools(200);
    test_backpressure();
    set_policy(PolicyMinWaste);
    test_random_pools(100);
    set_policy(PolicyThreshold);
    idle_allowed = 0;
    test_random_pools(120);

    while (pending_plans.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
